### sv/lkde_pkg.sv
package lkde_pkg;

    localparam int KEY_W           = 15;
    localparam int LIMIT_W         = 16;
    localparam int LANES           = 3;
    localparam int POSITIONS       = 5;
    localparam int DIGITS          = 10;
    localparam int DEF_SAMPLE_BITS = 10;
    localparam int DEF_VALUE_BITS  = 16;
    localparam int TH_W            = 10;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd9999;

    typedef logic [KEY_W-1:0] t_key;
    typedef t_key [POSITIONS-1:0] t_key_map;
    typedef logic [3:0] t_key_idx;
    typedef logic [3:0] t_digit;

    // ladder position of one channel, or nothing pressed
    typedef enum logic [2:0] {
        POS_0    = 3'd0,
        POS_1    = 3'd1,
        POS_2    = 3'd2,
        POS_3    = 3'd3,
        POS_4    = 3'd4,
        POS_NONE = 3'd5
    } t_pos;

    localparam logic [TH_W-1:0] TH0 = 10'd82;
    localparam logic [TH_W-1:0] TH1 = 10'd290;
    localparam logic [TH_W-1:0] TH2 = 10'd525;
    localparam logic [TH_W-1:0] TH3 = 10'd747;
    localparam logic [TH_W-1:0] TH4 = 10'd942;

    localparam t_key_idx KEY_CLR = 4'd4;

    // board wiring, position 0 in the lowest slot
    localparam t_key_map MAP_A = {15'h0080, 15'h1000, 15'h2000, 15'h0040, 15'h0100};
    localparam t_key_map MAP_B = {15'h0020, 15'h0400, 15'h0010, 15'h0800, 15'h4000};
    localparam t_key_map MAP_C = {15'h0004, 15'h0001, 15'h0002, 15'h0008, 15'h0200};

    // digits 1..9 then 0, highest priority first
    localparam t_key_idx DIGIT_BIT [DIGITS] = '{
        4'd1, 4'd6, 4'd11, 4'd3, 4'd0, 4'd10, 4'd12, 4'd7, 4'd2, 4'd5
    };
    localparam t_digit DIGIT_VAL [DIGITS] = '{
        4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd0
    };

    typedef struct packed {
        t_key               keys_held;
        t_key               keys_pressed;
        logic [LIMIT_W-1:0] entry_value;
        logic               entry_changed;
    } t_result;

endpackage

### sv/lkde_lane.sv
module lkde_lane #(
    parameter int                SAMPLE_BITS = lkde_pkg::DEF_SAMPLE_BITS,
    parameter lkde_pkg::t_key_map KEY_MAP    = lkde_pkg::MAP_A
) (
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output lkde_pkg::t_key         o_keys
);
    import lkde_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > TH_W) ? SAMPLE_BITS : TH_W;

    logic [CMP_W-1:0] s_ext;
    t_pos             pos;

    assign s_ext = CMP_W'(i_sample);

    always_comb begin
        priority if (s_ext <= CMP_W'(TH0)) pos = POS_0;
        else if (s_ext <= CMP_W'(TH1))     pos = POS_1;
        else if (s_ext <= CMP_W'(TH2))     pos = POS_2;
        else if (s_ext <= CMP_W'(TH3))     pos = POS_3;
        else if (s_ext <= CMP_W'(TH4))     pos = POS_4;
        else                               pos = POS_NONE;
    end

    always_comb begin
        unique case (pos)
            POS_0:   o_keys = KEY_MAP[0];
            POS_1:   o_keys = KEY_MAP[1];
            POS_2:   o_keys = KEY_MAP[2];
            POS_3:   o_keys = KEY_MAP[3];
            POS_4:   o_keys = KEY_MAP[4];
            default: o_keys = '0;
        endcase
    end

endmodule

### sv/lkde_merge.sv
module lkde_merge #(
    parameter int VALUE_BITS = lkde_pkg::DEF_VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  lkde_pkg::t_key                i_lane_keys [lkde_pkg::LANES],
    input  logic [lkde_pkg::LIMIT_W-1:0]  i_limit,
    output lkde_pkg::t_result             o_result
);
    import lkde_pkg::*;

    localparam int PROD_W = VALUE_BITS + 4;
    localparam int CMP_W  = (VALUE_BITS > LIMIT_W) ? VALUE_BITS : LIMIT_W;

    t_key                  r_prev_keys;
    logic [VALUE_BITS-1:0] r_accum;

    t_key                  held;
    t_key                  pressed;
    logic                  hit;
    t_digit                digit;
    logic [PROD_W-1:0]     prod;
    logic [VALUE_BITS-1:0] v_dig;
    logic [VALUE_BITS-1:0] v_key;
    logic                  at_limit;
    logic [VALUE_BITS-1:0] n_accum;
    logic [CMP_W-1:0]      v_wide;

    assign held    = i_lane_keys[0] | i_lane_keys[1] | i_lane_keys[2];
    assign pressed = held & ~r_prev_keys;

    // lowest priority first so the first digit in order wins
    always_comb begin
        hit   = 1'b0;
        digit = '0;
        for (int i = DIGITS - 1; i >= 0; i--) begin
            if (pressed[DIGIT_BIT[i]]) begin
                hit   = 1'b1;
                digit = DIGIT_VAL[i];
            end
        end
    end

    // times ten as shift and add, clamped at full width
    assign prod  = (PROD_W'(r_accum) << 3) + (PROD_W'(r_accum) << 1) + PROD_W'(digit);
    assign v_dig = (prod > PROD_W'({VALUE_BITS{1'b1}})) ? {VALUE_BITS{1'b1}}
                                                         : prod[VALUE_BITS-1:0];

    always_comb begin
        priority if (hit)         v_key = v_dig;
        else if (pressed[KEY_CLR]) v_key = '0;
        else                       v_key = r_accum;
    end

    assign at_limit = CMP_W'(v_key) >= CMP_W'(i_limit);
    assign n_accum  = at_limit ? VALUE_BITS'(CMP_W'(i_limit)) : v_key;
    assign v_wide   = CMP_W'(n_accum);

    assign o_result.keys_held     = held;
    assign o_result.keys_pressed  = pressed;
    assign o_result.entry_value   = v_wide[LIMIT_W-1:0];
    assign o_result.entry_changed = hit | pressed[KEY_CLR] | at_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_keys <= '0;
            r_accum     <= '0;
        end else if (i_accept) begin
            r_prev_keys <= held;
            r_accum     <= n_accum;
        end
    end

endmodule

### sv/ladder_keypad_decimal_entry_top.sv
// channel   direction  handshake              payload
// in        input      i_in_valid/o_in_stall   i_ladder_a, i_ladder_b, i_ladder_c
// out       output     o_out_valid/i_out_stall o_keys_held, o_keys_pressed,
//                                              o_entry_value, o_entry_changed
// cfg       input      i_cfg_wr_en             i_cfg_wr_data (entry limit)
// one item per cycle while o_in_stall is low: three lanes classify, the merge
// stage updates key and entry state in the same cycle, and the result is
// registered; an output register plus a skid register keep input transfers going
// while a result waits; o_in_stall rises only when both are full
// synchronous active-low reset clears key history and entry value and sets the limit to 9999
module ladder_keypad_decimal_entry_top #(
    parameter int SAMPLE_BITS = lkde_pkg::DEF_SAMPLE_BITS,
    parameter int VALUE_BITS  = lkde_pkg::DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [SAMPLE_BITS-1:0]       i_ladder_a,
    input  logic [SAMPLE_BITS-1:0]       i_ladder_b,
    input  logic [SAMPLE_BITS-1:0]       i_ladder_c,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [lkde_pkg::KEY_W-1:0]   o_keys_held,
    output logic [lkde_pkg::KEY_W-1:0]   o_keys_pressed,
    output logic [lkde_pkg::LIMIT_W-1:0] o_entry_value,
    output logic                         o_entry_changed,
    input  logic                         i_cfg_wr_en,
    input  logic [lkde_pkg::LIMIT_W-1:0] i_cfg_wr_data
);
    import lkde_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    t_key               lane_keys [LANES];
    t_result            result;
    logic               accept;
    logic               out_free;

    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    lkde_lane #(.SAMPLE_BITS(SAMPLE_BITS), .KEY_MAP(MAP_A)) u_lane_a (
        .i_sample (i_ladder_a),
        .o_keys   (lane_keys[0])
    );

    lkde_lane #(.SAMPLE_BITS(SAMPLE_BITS), .KEY_MAP(MAP_B)) u_lane_b (
        .i_sample (i_ladder_b),
        .o_keys   (lane_keys[1])
    );

    lkde_lane #(.SAMPLE_BITS(SAMPLE_BITS), .KEY_MAP(MAP_C)) u_lane_c (
        .i_sample (i_ladder_c),
        .o_keys   (lane_keys[2])
    );

    lkde_merge #(.VALUE_BITS(VALUE_BITS)) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_lane_keys (lane_keys),
        .i_limit     (r_limit),
        .o_result    (result)
    );

    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid & ~r_skid_valid;
    // output register empties or is taken this cycle
    assign out_free   = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid | accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : result;
        end else if (accept) begin
            r_skid <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_keys_held     = r_out.keys_held;
    assign o_keys_pressed  = r_out.keys_pressed;
    assign o_entry_value   = r_out.entry_value;
    assign o_entry_changed = r_out.entry_changed;

endmodule
